FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ESD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ESD_ASSERT_IMPL(label, clk, rst, ante, cons)

`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/esd_pkg.sv
`default_nettype none

package esd_pkg;

   localparam logic [1:0] ModeNormal = 2'd0;
   localparam logic [1:0] ModeEsc    = 2'd1;
   localparam logic [1:0] ModeHexHi  = 2'd2;
   localparam logic [1:0] ModeHexLo  = 2'd3;

   localparam logic [7:0] CharBackslash   = 8'h5C;
   localparam logic [7:0] CharDoubleQuote = 8'h22;
   localparam logic [7:0] CharSingleQuote = 8'h27;
   localparam logic [7:0] CharQuestion    = 8'h3F;
   localparam logic [7:0] CharNewline     = 8'h0A;
   localparam logic [7:0] CharTab         = 8'h09;
   localparam logic [7:0] CharReturn      = 8'h0D;
   localparam logic [7:0] CharBackspace   = 8'h08;
   localparam logic [7:0] CharLowerN      = 8'h6E;
   localparam logic [7:0] CharLowerT      = 8'h74;
   localparam logic [7:0] CharLowerR      = 8'h72;
   localparam logic [7:0] CharLowerB      = 8'h62;
   localparam logic [7:0] CharLowerX      = 8'h78;
   localparam logic [7:0] CharDigit0      = 8'h30;
   localparam logic [7:0] CharDigit9      = 8'h39;
   localparam logic [7:0] CharLowerA      = 8'h61;
   localparam logic [7:0] CharLowerF      = 8'h66;
   localparam logic [7:0] CharUpperA      = 8'h41;
   localparam logic [7:0] CharUpperF      = 8'h46;

   localparam logic [4:0] HexNone = 5'h10;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_done;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } dec_out_type;

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = HexNone;
      if (c >= CharDigit0 && c <= CharDigit9) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= CharLowerA && c <= CharLowerF) ||
                   (c >= CharUpperA && c <= CharUpperF)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/esd_decode.sv
`default_nettype none
`include "assert_macros.svh"

module esd_decode import esd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  ch,
   input  wire logic        string_end,
   output dec_out_type      dec
);

   logic [1:0] mode_ff, mode_in;
   logic [3:0] nibble_ff, nibble_in;
   logic       hvalid_ff, hvalid_in;
   logic [1:0] n;
   logic [7:0] b0, b1;
   logic [4:0] h;

   always_comb begin
      mode_in   = mode_ff;
      nibble_in = nibble_ff;
      hvalid_in = hvalid_ff;
      n         = 2'd0;
      b0        = CharQuestion;
      b1        = ch;
      h         = hex_value(ch);
      unique case (mode_ff)
         ModeNormal: begin
            if (ch == CharBackslash) begin
               mode_in = ModeEsc;
               if (string_end) begin
                  n  = 2'd1;
                  b0 = CharBackslash;
               end
            end else begin
               n  = 2'd1;
               b0 = ch;
            end
         end
         ModeEsc: begin
            mode_in = ModeNormal;
            n       = 2'd1;
            unique case (ch)
               CharLowerN:      b0 = CharNewline;
               CharLowerT:      b0 = CharTab;
               CharLowerR:      b0 = CharReturn;
               CharLowerB:      b0 = CharBackspace;
               CharBackslash:   b0 = CharBackslash;
               CharDoubleQuote: b0 = CharDoubleQuote;
               CharSingleQuote: b0 = CharSingleQuote;
               CharLowerX: begin
                  mode_in = ModeHexHi;
                  n       = string_end ? 2'd1 : 2'd0;
                  b0      = CharQuestion;
               end
               default: begin
                  n  = 2'd2;
                  b0 = CharBackslash;
               end
            endcase
         end
         ModeHexHi: begin
            hvalid_in = !h[4];
            nibble_in = h[4] ? 4'd0 : h[3:0];
            mode_in   = ModeHexLo;
            if (string_end) begin
               n  = 2'd1;
               b0 = CharQuestion;
            end
         end
         default: begin
            n         = 2'd1;
            b0        = (hvalid_ff && !h[4]) ? {nibble_ff, h[3:0]} : CharQuestion;
            mode_in   = ModeNormal;
            nibble_in = 4'd0;
            hvalid_in = 1'b0;
         end
      endcase
      if (string_end) begin
         mode_in   = ModeNormal;
         nibble_in = 4'd0;
         hvalid_in = 1'b0;
      end
   end

   always_comb begin
      dec.count              = n;
      dec.first.out_byte     = b0;
      dec.first.run_last     = (n == 2'd1);
      dec.first.string_done  = string_end && (n == 2'd1);
      dec.second.out_byte    = b1;
      dec.second.run_last    = 1'b1;
      dec.second.string_done = string_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ModeNormal;
         nibble_ff <= 4'd0;
         hvalid_ff <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         nibble_ff <= nibble_in;
         hvalid_ff <= hvalid_in;
      end
   end

   `ESD_ASSERT_NEXT(a_end_clears_mode, clock, reset, accept && string_end, mode_ff == ModeNormal)
   `ESD_ASSERT_IMPL(a_end_emits, clock, reset, accept && string_end, n != 2'd0)
   `ESD_ASSERT_IMPL(a_hvalid_mode, clock, reset, hvalid_ff || nibble_ff != 4'd0, mode_ff == ModeHexLo)

endmodule

`default_nettype wire

FILE: rtl/esd_out_queue.sv
`default_nettype none
`include "assert_macros.svh"

module esd_out_queue import esd_pkg::*; #(
   parameter int Depth = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   input  wire dec_out_type push,
   output logic             full2,
   output logic             pop_valid,
   input  wire logic        pop,
   output result_type       head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   result_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in, wr1, wr2;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [1:0]      pushed;

   function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr1    = inc(wr_ff);
      wr2    = inc(wr1);
      pushed = push_valid ? push.count : 2'd0;
      unique case (pushed)
         2'd0:    wr_in = wr_ff;
         2'd1:    wr_in = wr1;
         default: wr_in = wr2;
      endcase
      rd_in  = pop ? inc(rd_ff) : rd_ff;
      cnt_in = cnt_ff + CntW'(pushed) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pushed != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (pushed == 2'd2) begin
         mem_ff[wr1] <= push.second;
      end
   end

   assign full2     = (cnt_ff > CntW'(Depth - 2));
   assign pop_valid = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   `ESD_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CntW'(Depth))
   `ESD_ASSERT_IMPL(a_room, clock, reset, pushed != 2'd0, cnt_ff <= CntW'(Depth - 2))
   `ESD_ASSERT_NEXT(a_push_shows, clock, reset, pushed != 2'd0, cnt_ff != '0)

endmodule

`default_nettype wire

FILE: rtl/escape_sequence_decoder.sv
// Channel  Direction  Payload                                        Handshake
// req      in         req_ch[7:0], req_string_end                    req_valid / req_stall
// rsp      out        rsp_out_byte[7:0], rsp_run_last, rsp_string_done rsp_valid / rsp_stall
//
// One input item per cycle while req_stall is low; each item yields zero, one or two results.
// Results enter the queue on accept and leave it one per cycle while rsp_stall is low.
// req_stall is high while the queue has fewer than two free slots; each two-result
// item puts two results in the queue, so a run of them or rsp_stall backs up the input.
// Synchronous active-high reset returns the decoder to plain text and empties the queue.
`default_nettype none

module escape_sequence_decoder import esd_pkg::*; #(
   parameter int QueueDepth = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_string_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last,
   output logic            rsp_string_done
);

   logic        accept;
   logic        full2;
   dec_out_type dec;
   result_type  head;

   assign accept = req_valid && !full2;
   assign req_stall = full2;

   esd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .ch         (req_ch),
      .string_end (req_string_end),
      .dec        (dec)
   );

   esd_out_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push       (dec),
      .full2      (full2),
      .pop_valid  (rsp_valid),
      .pop        (rsp_valid && !rsp_stall),
      .head       (head)
   );

   assign rsp_out_byte    = head.out_byte;
   assign rsp_run_last    = head.run_last;
   assign rsp_string_done = head.string_done;

endmodule

`default_nettype wire
